FILE: src/idr_pkg.sv
// ----------------------------------------------------------------------------
// idr_pkg: shared types and constants of the IMU dead-reckoning integrator
// Holds the serial multiplier width, the high-pass coefficients and the
// multiplier request word.
// ----------------------------------------------------------------------------
`default_nettype none
package idr_pkg;

  // Operand width of the serial multiplier: covers a 33-bit difference
  // and a 17-bit unsigned period with its sign bit.
  localparam int MUL_W = 34;

  // High-pass coefficients, Q2.30.
  localparam logic [31:0] HP_A = 32'd1072394213;
  localparam logic [31:0] HP_B = 32'd1071046602;
  localparam int HP_SHIFT = 30;

  localparam logic [31:0] TEMP_OFFSET = 32'd21;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mreq_t;

endpackage
`default_nettype wire

FILE: src/idr_sermul.sv
// ----------------------------------------------------------------------------
// idr_sermul: bit-serial signed multiplier
// Shift-add over one multiplier bit per cycle; the sign bit subtracts.
// ----------------------------------------------------------------------------
`default_nettype none
module idr_sermul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire idr_pkg::mreq_t                req,
  output logic                               busy,
  output logic                               done,
  output logic [2*idr_pkg::MUL_W-1:0]        prod
);
  import idr_pkg::*;

  localparam int CW = $clog2(MUL_W + 1);

  logic [MUL_W:0]   hi_r, hi_nxt;
  logic [MUL_W-1:0] lo_r, lo_nxt;
  logic [MUL_W-1:0] a_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MUL_W:0]   a_ext;
  logic [MUL_W:0]   addend;
  logic [MUL_W:0]   sum;
  logic             last;

  assign a_ext  = {a_r[MUL_W-1], a_r};
  assign last   = (cnt_r == CW'(MUL_W - 1));
  assign addend = lo_r[0] ? (last ? (~a_ext + 1'b1) : a_ext) : '0;
  assign sum    = hi_r + addend;

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      hi_nxt   = '0;
      lo_nxt   = req.b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // add the partial product, then shift one bit into the low word
      hi_nxt  = {sum[MUL_W], sum[MUL_W:1]};
      lo_nxt  = {sum[0], lo_r[MUL_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (req.start) begin
      a_r <= req.a;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = {hi_r[MUL_W-1:0], lo_r};

endmodule
`default_nettype wire

FILE: src/idr_serdiv.sv
// ----------------------------------------------------------------------------
// idr_serdiv: bit-serial bias mean divider
// Restoring division of sum * 2^FRAC_BITS by a constant, truncating
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module idr_serdiv #(
  parameter int DIVISOR   = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] sum,
  output logic             busy,
  output logic             done,
  output logic [31:0]      mean
);
  localparam int DW  = 32 + FRAC_BITS;
  localparam int RBW = $clog2(DIVISOR + 1);
  localparam int CW  = $clog2(DW + 1);

  logic [DW-1:0]  dq_r, dq_nxt;
  logic [RBW-1:0] rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           neg_r;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [RBW:0]   rem_sh;
  logic [RBW:0]   rem_sub;
  logic           ge;
  logic [31:0]    mag;

  assign mag     = sum[31] ? (~sum + 1'b1) : sum;
  assign rem_sh  = {rem_r, dq_r[DW-1]};
  assign ge      = (rem_sh >= (RBW+1)'(DIVISOR));
  assign rem_sub = rem_sh - (RBW+1)'(DIVISOR);

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = DW'(mag) << FRAC_BITS;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DW-2:0], ge};
      rem_nxt = ge ? rem_sub[RBW-1:0] : rem_sh[RBW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      neg_r <= sum[31];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign mean = neg_r ? (~dq_r[31:0] + 1'b1) : dq_r[31:0];

endmodule
`default_nettype wire

FILE: src/imu_dead_reckoning_integrator.sv
// ----------------------------------------------------------------------------
// imu_dead_reckoning_integrator: bias calibration and dead reckoning
// Averages the first CAL_SAMPLES frames into biases, then corrects, scales,
// high-passes and integrates each frame into heading, velocity and position.
// ----------------------------------------------------------------------------
//
//  channel  handshake          word
//  -------  -----------------  ------------------------------------------
//  in       in_valid/in_ready  func, accel x/y, gyro z, temperature raw
//  out      out_valid/out_rdy  pos x/y, vel x/y, heading, temp, calibrating
//  cfg      psel/penable APB   four scales and the sample period
//
//  A sensor frame after calibration runs 13 products through one bit-serial
//  multiplier of 34 bits. A velocity reset or a calibration frame uses no
//  serial unit, but the frame that ends calibration runs three divisions,
//  one per bias, in the serial divider. Reset is synchronous, active low; the
//  scales reset to 65536, the period to 655, navigation state to zero.
//  A finished word waits in the output register; the next input word is
//  taken meanwhile, and the sequencer holds its result until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none
module imu_dead_reckoning_integrator #(
  parameter int CAL_SAMPLES = 256,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [15:0] in_accel_x_raw,
  input  wire logic [15:0] in_accel_y_raw,
  input  wire logic [15:0] in_gyro_z_raw,
  input  wire logic [15:0] in_temp_raw,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pos_x,
  output logic [31:0]      out_pos_y,
  output logic [31:0]      out_vel_x,
  output logic [31:0]      out_vel_y,
  output logic [31:0]      out_heading,
  output logic [31:0]      out_temperature,
  output logic             out_calibrating,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import idr_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int PW    = 2 * MUL_W;

  // register map
  localparam logic [2:0] REG_SCALE_AX = 3'd0;
  localparam logic [2:0] REG_SCALE_AY = 3'd1;
  localparam logic [2:0] REG_SCALE_GZ = 3'd2;
  localparam logic [2:0] REG_SCALE_T  = 3'd3;
  localparam logic [2:0] REG_PERIOD   = 3'd4;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // multiplier steps of one frame
  localparam logic [3:0] OP_AX   = 4'd0;
  localparam logic [3:0] OP_AY   = 4'd1;
  localparam logic [3:0] OP_GZ   = 4'd2;
  localparam logic [3:0] OP_TC   = 4'd3;
  localparam logic [3:0] OP_HEAD = 4'd4;
  localparam logic [3:0] OP_HPA0 = 4'd5;
  localparam logic [3:0] OP_HPB0 = 4'd6;
  localparam logic [3:0] OP_HPA1 = 4'd7;
  localparam logic [3:0] OP_HPB1 = 4'd8;
  localparam logic [3:0] OP_VEL0 = 4'd9;
  localparam logic [3:0] OP_POS0 = 4'd10;
  localparam logic [3:0] OP_VEL1 = 4'd11;
  localparam logic [3:0] OP_POS1 = 4'd12;

  // ---------------- configuration ----------------
  logic [31:0] scale_ax_r, scale_ay_r, scale_gz_r, scale_t_r;
  logic [16:0] period_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_ax_r <= 32'd65536;
      scale_ay_r <= 32'd65536;
      scale_gz_r <= 32'd65536;
      scale_t_r  <= 32'd65536;
      period_r   <= 17'd655;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE_AX: scale_ax_r <= pwdata;
        REG_SCALE_AY: scale_ay_r <= pwdata;
        REG_SCALE_GZ: scale_gz_r <= pwdata;
        REG_SCALE_T:  scale_t_r  <= pwdata;
        REG_PERIOD:   period_r   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE_AX: prdata = scale_ax_r;
      REG_SCALE_AY: prdata = scale_ay_r;
      REG_SCALE_GZ: prdata = scale_gz_r;
      REG_SCALE_T:  prdata = scale_t_r;
      REG_PERIOD:   prdata = {15'd0, period_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  logic [2:0]       state_r;
  logic [3:0]       op_r;
  logic [1:0]       k_r;
  logic [CNT_W-1:0] cal_cnt_r;
  logic [31:0]      bsum_r [3];
  logic [31:0]      bmean_r [3];
  logic [31:0]      pax_r [2];
  logic [31:0]      pfo_r [2];
  logic [31:0]      vel_r [2];
  logic [31:0]      pos_r [2];
  logic [31:0]      head_r;
  logic [31:0]      temp_r;
  logic             cal_item_r;

  // raw word and per-frame scratch
  logic [15:0] raw_ax_r, raw_ay_r, raw_gz_r, raw_t_r;
  logic [31:0] ax_r, ay_r, gz_r, tc_r;
  logic [31:0] p1hi_r;
  logic [29:0] p1lo_r;

  logic        in_acc;
  logic        cal;
  logic        out_load;

  assign cal      = (cal_cnt_r < CNT_W'(CAL_SAMPLES));
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_load = (state_r == S_DONE) & (~out_valid | out_ready);

  // ---------------- serial units ----------------
  mreq_t          mreq;
  logic           mul_busy, mul_done;
  logic [PW-1:0]  prod;
  logic           div_busy, div_done;
  logic [31:0]    div_mean;

  idr_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  idr_serdiv #(
    .DIVISOR   (CAL_SAMPLES),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DSTART),
    .sum   (bsum_r[k_r]),
    .busy  (div_busy),
    .done  (div_done),
    .mean  (div_mean)
  );

  // raw count to Q value, wrapped to 32 bits
  function automatic logic [31:0] qraw(input logic [15:0] raw);
    qraw = {{16{raw[15]}}, raw} << FRAC_BITS;
  endfunction

  function automatic logic [MUL_W-1:0] sx(input logic [31:0] v);
    sx = {{(MUL_W-32){v[31]}}, v};
  endfunction

  // operand select for each step
  logic [MUL_W-1:0] per_op;
  assign per_op = MUL_W'(period_r);

  always_comb begin
    mreq.start = (state_r == S_MSTART);
    mreq.a     = '0;
    mreq.b     = '0;
    case (op_r)
      OP_AX: begin
        mreq.a = sx(qraw(raw_ax_r) - bmean_r[0]);
        mreq.b = sx(scale_ax_r);
      end
      OP_AY: begin
        mreq.a = sx(qraw(raw_ay_r) - bmean_r[1]);
        mreq.b = sx(scale_ay_r);
      end
      OP_GZ: begin
        mreq.a = sx(qraw(raw_gz_r) - bmean_r[2]);
        mreq.b = sx(scale_gz_r);
      end
      OP_TC: begin
        mreq.a = sx(qraw(raw_t_r));
        mreq.b = sx(scale_t_r);
      end
      OP_HEAD: begin
        mreq.a = sx(gz_r);
        mreq.b = per_op;
      end
      OP_HPA0: begin
        mreq.a = sx(HP_A);
        mreq.b = sx(ax_r) - sx(pax_r[0]);
      end
      OP_HPB0: begin
        mreq.a = sx(HP_B);
        mreq.b = sx(pfo_r[0]);
      end
      OP_HPA1: begin
        mreq.a = sx(HP_A);
        mreq.b = sx(ay_r) - sx(pax_r[1]);
      end
      OP_HPB1: begin
        mreq.a = sx(HP_B);
        mreq.b = sx(pfo_r[1]);
      end
      OP_VEL0: begin
        mreq.a = sx(pfo_r[0]);
        mreq.b = per_op;
      end
      OP_POS0: begin
        mreq.a = sx(vel_r[0]);
        mreq.b = per_op;
      end
      OP_VEL1: begin
        mreq.a = sx(pfo_r[1]);
        mreq.b = per_op;
      end
      OP_POS1: begin
        mreq.a = sx(vel_r[1]);
        mreq.b = per_op;
      end
      default: ;
    endcase
  end

  // product taps: Q shift and the high-pass shift with its low carry
  logic [31:0] prod_q;
  logic [30:0] hp_lo;
  logic [31:0] hp_y;

  assign prod_q = prod[FRAC_BITS +: 32];
  assign hp_lo  = {1'b0, p1lo_r} + {1'b0, prod[HP_SHIFT-1:0]};
  assign hp_y   = p1hi_r + prod[HP_SHIFT +: 32] + {31'd0, hp_lo[30]};

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      op_r       <= OP_AX;
      k_r        <= '0;
      cal_cnt_r  <= '0;
      head_r     <= '0;
      temp_r     <= '0;
      cal_item_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bsum_r[i]  <= '0;
        bmean_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        pax_r[i] <= '0;
        pfo_r[i] <= '0;
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cal_item_r <= cal;
            if (in_func) begin
              // velocity reset, at any time
              vel_r[0] <= '0;
              vel_r[1] <= '0;
              state_r  <= S_DONE;
            end else if (cal) begin
              // accumulate raw counts toward the bias
              bsum_r[0] <= bsum_r[0] + {{16{in_accel_x_raw[15]}}, in_accel_x_raw};
              bsum_r[1] <= bsum_r[1] + {{16{in_accel_y_raw[15]}}, in_accel_y_raw};
              bsum_r[2] <= bsum_r[2] + {{16{in_gyro_z_raw[15]}}, in_gyro_z_raw};
              cal_cnt_r <= cal_cnt_r + 1'b1;
              k_r       <= '0;
              if (cal_cnt_r == CNT_W'(CAL_SAMPLES - 1)) begin
                state_r <= S_DSTART;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              // hold the raw word for the whole product sequence
              raw_ax_r <= in_accel_x_raw;
              raw_ay_r <= in_accel_y_raw;
              raw_gz_r <= in_gyro_z_raw;
              raw_t_r  <= in_temp_raw;
              op_r     <= OP_AX;
              state_r  <= S_MSTART;
            end
          end
        end
        S_MSTART: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            case (op_r)
              OP_AX:   ax_r   <= prod_q;
              OP_AY:   ay_r   <= prod_q;
              OP_GZ:   gz_r   <= prod_q;
              OP_TC:   tc_r   <= prod_q;
              OP_HEAD: head_r <= head_r + prod_q;
              OP_HPA0, OP_HPA1: begin
                p1hi_r <= prod[HP_SHIFT +: 32];
                p1lo_r <= prod[HP_SHIFT-1:0];
              end
              OP_HPB0: begin
                pax_r[0] <= ax_r;
                pfo_r[0] <= hp_y;
              end
              OP_HPB1: begin
                pax_r[1] <= ay_r;
                pfo_r[1] <= hp_y;
              end
              OP_VEL0: vel_r[0] <= vel_r[0] + prod_q;
              OP_POS0: pos_r[0] <= pos_r[0] + prod_q;
              OP_VEL1: vel_r[1] <= vel_r[1] + prod_q;
              OP_POS1: begin
                pos_r[1] <= pos_r[1] + prod_q;
                temp_r   <= tc_r + (TEMP_OFFSET << FRAC_BITS);
              end
              default: ;
            endcase
            if (op_r == OP_POS1) begin
              state_r <= S_DONE;
            end else begin
              op_r    <= op_r + 1'b1;
              state_r <= S_MSTART;
            end
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            bmean_r[k_r] <= div_mean;
            if (k_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_x       <= pos_r[0];
      out_pos_y       <= pos_r[1];
      out_vel_x       <= vel_r[0];
      out_vel_y       <= vel_r[1];
      out_heading     <= head_r;
      out_temperature <= temp_r;
      out_calibrating <= cal_item_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // a new word appears only from the completion state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output word loaded outside completion");

  // never restart the multiplier mid-product
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !mul_busy)
    else $error("multiplier started while busy");

  // never restart the divider mid-quotient
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTART) |-> !div_busy)
    else $error("divider started while busy");

  // calibration count saturates at the sample count
  a_cal_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count overran");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: IMU dead-reckoning integrator
// Drives bias-calibration frames, velocity resets and sensor frames through
// the valid/ready channels with random idling on both sides. Expected words
// come from a cycle-free navigation model kept in step with every accepted
// input word, or from the known word of a typed directed row. Scales and
// sample period are reprogrammed over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAL_FRAMES = 256;
  localparam int FRAC       = 16;
  localparam int SETTLE     = 600;

  localparam logic FUNC_FRAME     = 1'b0;
  localparam logic FUNC_VEL_RESET = 1'b1;

  localparam int REG_SCALE_AX  = 0;
  localparam int REG_SCALE_AY  = 1;
  localparam int REG_SCALE_GZ  = 2;
  localparam int REG_SCALE_T   = 3;
  localparam int REG_PERIOD    = 4;

  typedef struct packed {
    logic        func;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] gz;
    logic [15:0] t;
  } imu_word_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] heading;
    logic [31:0] temperature;
    logic        calibrating;
  } nav_word_t;

  // directed row: typed rows carry a known expected word
  typedef struct {
    imu_word_t w;
    bit        typed;
    nav_word_t known;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  imu_word_t   in_word;
  logic        out_valid;
  logic        out_ready;
  nav_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  imu_dead_reckoning_integrator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_word.func),
    .in_accel_x_raw (in_word.ax),
    .in_accel_y_raw (in_word.ay),
    .in_gyro_z_raw  (in_word.gz),
    .in_temp_raw    (in_word.t),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_x      (out_word.pos_x),
    .out_pos_y      (out_word.pos_y),
    .out_vel_x      (out_word.vel_x),
    .out_vel_y      (out_word.vel_y),
    .out_heading    (out_word.heading),
    .out_temperature(out_word.temperature),
    .out_calibrating(out_word.calibrating),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Navigation model state, a private copy of the registers and the state.
  logic [31:0] m_scale [4];
  logic [16:0] m_period;
  logic [31:0] m_bias_sum [3];
  logic [31:0] m_bias_mean [3];
  int          m_cal_count;
  logic [31:0] m_prev_x [2];
  logic [31:0] m_prev_y [2];
  logic [31:0] m_vel [2];
  logic [31:0] m_pos [2];
  logic [31:0] m_heading;
  logic [31:0] m_temp;

  nav_word_t expected_nav [$];
  int        mismatches;
  int        n_cal, n_vreset, n_frames, n_checked;
  bit        calm;   // no idling on either side while set

  function automatic longint sx32(logic [31:0] x);
    return longint'($signed(x));
  endfunction

  // floor(v / 2^s), keep the low 32 bits
  function automatic logic [31:0] floor_shift(longint v, int s);
    longint r;
    r = v >>> s;
    return r[31:0];
  endfunction

  function automatic logic [31:0] qmul(logic [31:0] a, longint b);
    return floor_shift(sx32(a) * b, FRAC);
  endfunction

  function automatic logic [31:0] scaled(logic [15:0] raw, logic [31:0] bias,
                                         logic [31:0] scale);
    longint      q;
    logic [31:0] d;
    q = longint'($signed(raw)) <<< FRAC;
    d = q[31:0] - bias;
    return qmul(d, sx32(scale));
  endfunction

  function automatic logic [31:0] hp_filter(int k, logic [31:0] x);
    longint      acc;
    logic [31:0] y;
    acc = longint'(idr_pkg::HP_A) * (sx32(x) - sx32(m_prev_x[k]))
        + longint'(idr_pkg::HP_B) * sx32(m_prev_y[k]);
    y = floor_shift(acc, idr_pkg::HP_SHIFT);
    m_prev_x[k] = x;
    m_prev_y[k] = y;
    return y;
  endfunction

  // Advance the navigation state by one input word, return the output word.
  function automatic nav_word_t advance_nav(imu_word_t w);
    nav_word_t   r;
    bit          cal;
    longint      per;
    logic [31:0] ax, ay, gz, tc, hp;
    logic [15:0] raw [3];
    cal = m_cal_count < CAL_FRAMES;
    per = longint'(m_period);
    raw[0] = w.ax; raw[1] = w.ay; raw[2] = w.gz;
    if (w.func == FUNC_VEL_RESET) begin
      m_vel[0] = '0;
      m_vel[1] = '0;
    end else if (cal) begin
      for (int i = 0; i < 3; i++)
        m_bias_sum[i] = m_bias_sum[i] + {{16{raw[i][15]}}, raw[i]};
      m_cal_count++;
      if (m_cal_count >= CAL_FRAMES) begin
        for (int i = 0; i < 3; i++) begin
          longint m;
          m = (sx32(m_bias_sum[i]) <<< FRAC) / longint'(CAL_FRAMES);
          m_bias_mean[i] = m[31:0];
        end
      end
    end else begin
      ax = scaled(w.ax, m_bias_mean[0], m_scale[REG_SCALE_AX]);
      ay = scaled(w.ay, m_bias_mean[1], m_scale[REG_SCALE_AY]);
      gz = scaled(w.gz, m_bias_mean[2], m_scale[REG_SCALE_GZ]);
      tc = scaled(w.t, 32'd0, m_scale[REG_SCALE_T]);
      m_heading = m_heading + qmul(gz, per);
      for (int k = 0; k < 2; k++) begin
        hp = hp_filter(k, (k == 0) ? ax : ay);
        m_vel[k] = m_vel[k] + qmul(hp, per);
        m_pos[k] = m_pos[k] + qmul(m_vel[k], per);
      end
      m_temp = tc + (idr_pkg::TEMP_OFFSET << FRAC);
    end
    r.pos_x       = m_pos[0];
    r.pos_y       = m_pos[1];
    r.vel_x       = m_vel[0];
    r.vel_y       = m_vel[1];
    r.heading     = m_heading;
    r.temperature = m_temp;
    r.calibrating = cal;
    return r;
  endfunction

  // Result checker and receiver-side stall generator.
  always @(posedge clk) begin
    nav_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (expected_nav.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected output word %h", $realtime, out_word);
        end else begin
          want = expected_nav.pop_front();
          if (out_word !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch pos %h/%h vel %h/%h hdg %h temp %h cal %b",
                       $realtime, out_word.pos_x, out_word.pos_y, out_word.vel_x,
                       out_word.vel_y, out_word.heading, out_word.temperature,
                       out_word.calibrating);
              $display("    expected pos %h/%h vel %h/%h hdg %h temp %h cal %b",
                       want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                       want.heading, want.temperature, want.calibrating);
            end
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Write one register over APB and mirror it into the model.
  task automatic write_reg(int idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PERIOD) m_period = value[16:0];
    else m_scale[idx] = value;
  endtask

  task automatic program_all(logic [31:0] sax, logic [31:0] say, logic [31:0] sgz,
                             logic [31:0] st, logic [16:0] per);
    write_reg(REG_SCALE_AX, sax);
    write_reg(REG_SCALE_AY, say);
    write_reg(REG_SCALE_GZ, sgz);
    write_reg(REG_SCALE_T, st);
    write_reg(REG_PERIOD, {15'd0, per});
  endtask

  // Drop valid, hold until every expected word is back, then let the
  // block settle before touching the registers.
  task automatic drain;
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_nav.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Present one word and wait for the handshake; predict on acceptance.
  task automatic send_word(imu_word_t w, bit typed, nav_word_t known);
    nav_word_t p;
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = advance_nav(w);
    expected_nav.push_back(typed ? known : p);
    if (w.func == FUNC_VEL_RESET) n_vreset++;
    else if (p.calibrating) n_cal++;
    else n_frames++;
  endtask

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_word_t rand_word(int reset_pct);
    imu_word_t w;
    w.func = ($urandom_range(0, 99) < reset_pct) ? FUNC_VEL_RESET : FUNC_FRAME;
    w.ax = rand_raw();
    w.ay = rand_raw();
    w.gz = rand_raw();
    w.t  = rand_raw();
    return w;
  endfunction

  function automatic stim_row_t row(logic f, logic [15:0] ax, logic [15:0] ay,
                                    logic [15:0] gz, logic [15:0] t, bit typed);
    stim_row_t r;
    r.w     = '{func: f, ax: ax, ay: ay, gz: gz, t: t};
    r.typed = typed;
    // during calibration nothing moves: all zero, calibrating high
    r.known = '{pos_x: 0, pos_y: 0, vel_x: 0, vel_y: 0, heading: 0,
                temperature: 0, calibrating: 1'b1};
    return r;
  endfunction

  initial begin
    stim_row_t cal_rows [$];
    stim_row_t run_rows [$];
    nav_word_t none;
    int        sent;
    none = '0;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    calm      = 1'b0;
    mismatches = 0;
    n_cal = 0; n_vreset = 0; n_frames = 0; n_checked = 0;
    for (int i = 0; i < 4; i++) m_scale[i] = 32'd65536;
    m_period = 17'd655;
    for (int i = 0; i < 3; i++) begin
      m_bias_sum[i] = '0;
      m_bias_mean[i] = '0;
    end
    for (int k = 0; k < 2; k++) begin
      m_prev_x[k] = '0; m_prev_y[k] = '0; m_vel[k] = '0; m_pos[k] = '0;
    end
    m_cal_count = 0;
    m_heading = '0;
    m_temp = '0;

    // Calibration rows: state stays at zero, so the words are known.
    cal_rows.push_back(row(FUNC_VEL_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1));
    cal_rows.push_back(row(FUNC_FRAME, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1));
    cal_rows.push_back(row(FUNC_FRAME, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1));
    cal_rows.push_back(row(FUNC_FRAME, 16'h0000, 16'hffff, 16'h0001, 16'h1234, 1));
    cal_rows.push_back(row(FUNC_VEL_RESET, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1));
    cal_rows.push_back(row(FUNC_FRAME, 16'hffff, 16'h0000, 16'h8000, 16'h7fff, 1));
    // After calibration: extremes, resets, zero input, all through the model.
    run_rows.push_back(row(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0));
    run_rows.push_back(row(FUNC_FRAME, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0));
    run_rows.push_back(row(FUNC_FRAME, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0));
    run_rows.push_back(row(FUNC_FRAME, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 0));
    run_rows.push_back(row(FUNC_VEL_RESET, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0));
    run_rows.push_back(row(FUNC_FRAME, 16'h8000, 16'h7fff, 16'hffff, 16'h0001, 0));
    run_rows.push_back(row(FUNC_FRAME, 16'h0100, 16'hff00, 16'h0080, 16'h0015, 0));
    run_rows.push_back(row(FUNC_VEL_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0));
    run_rows.push_back(row(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Program reset values first; calibration ignores the scales anyway.
    program_all(32'd65536, 32'd65536, 32'd65536, 32'd65536, 17'd655);

    foreach (cal_rows[i]) send_word(cal_rows[i].w, 1'b1, cal_rows[i].known);
    // Finish averaging with random frames and a few velocity resets.
    while (m_cal_count < CAL_FRAMES) send_word(rand_word(4), 1'b0, none);
    foreach (run_rows[i]) send_word(run_rows[i].w, 1'b0, none);
    sent = cal_rows.size() + run_rows.size();

    // Random phases, each under a new register setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: program_all(32'd65536, 32'd65536, 32'd65536, 32'd65536, 17'd655);
        1: program_all(32'h7fffffff, 32'h80000000, 32'd0, 32'd1, 17'd65536);
        2: program_all(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 17'd0);
        3: program_all($urandom, $urandom, $urandom, $urandom,
                       17'($urandom_range(0, 65536)));
        4: program_all(32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
                       32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
                       32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
                       32'h80000000, 17'($urandom_range(1, 3000)));
        default: program_all(32'd131072, 32'hffff0000, 32'd32768, 32'd65536, 17'd65535);
      endcase
      for (int n = 0; n < 140; n++) begin
        // one long stretch with no idling on either side
        calm = (ph == 3) && (n >= 30) && (n < 110);
        send_word(rand_word(6), 1'b0, none);
      end
      calm = 1'b0;
    end

    drain();
    $display("Covered %0d calibration words, %0d velocity resets, %0d sensor frames;",
             n_cal, n_vreset, n_frames);
    $display("%0d output words checked under six register settings.", n_checked);
    if (mismatches == 0 && expected_nav.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/idr_pkg.sv
src/idr_sermul.sv
src/idr_serdiv.sv
src/imu_dead_reckoning_integrator.sv
tb/testbench.sv
